// ----- hw/rtl/cpr2x_pkg.sv -----
// Package for the row-2x execute block: item, result and register-file types,
// opcode codes, flag positions and cycle counts.
// No dependencies.
`default_nettype none

package cpr2x_pkg;

    // low nibble of the opcode, instruction 0x20 + code
    typedef enum logic [3:0] {
        FN_JR_NZ    = 4'h0,
        FN_LD_HL_NN = 4'h1,
        FN_LDI_M_A  = 4'h2,
        FN_INC_HL   = 4'h3,
        FN_INC_H    = 4'h4,
        FN_DEC_H    = 4'h5,
        FN_LD_H_N   = 4'h6,
        FN_DAA      = 4'h7,
        FN_JR_Z     = 4'h8,
        FN_ADD_HLHL = 4'h9,
        FN_LDI_A_M  = 4'hA,
        FN_DEC_HL   = 4'hB,
        FN_INC_L    = 4'hC,
        FN_DEC_L    = 4'hD,
        FN_LD_L_N   = 4'hE,
        FN_CPL      = 4'hF
    } func_t;

    // flag bit positions inside flags
    localparam int unsigned FLAG_Z = 3;
    localparam int unsigned FLAG_N = 2;
    localparam int unsigned FLAG_H = 1;
    localparam int unsigned FLAG_C = 0;

    localparam logic [3:0] COST_1M = 4'd4;
    localparam logic [3:0] COST_2M = 4'd8;
    localparam logic [3:0] COST_3M = 4'd12;

    localparam int unsigned IN_TDATA_W  = 32;
    localparam int unsigned OUT_TDATA_W = 80;

    typedef struct packed {
        logic [7:0]  mem_data;
        logic [7:0]  imm_hi;
        logic [7:0]  imm_lo;
        logic [3:0]  func;
    } item_t;

    typedef struct packed {
        logic [15:0] pc;
        logic [3:0]  flags;
        logic [7:0]  low;
        logic [7:0]  high;
        logic [7:0]  acc;
    } cpu_state_t;

    typedef struct packed {
        logic [3:0]  clock_cost;
        logic [7:0]  write_data;
        logic [15:0] write_addr;
        logic        write_enable;
        logic [15:0] pc_out;
        logic        carry_flag;
        logic        half_carry_flag;
        logic        subtract_flag;
        logic        zero_flag;
        logic [7:0]  low_out;
        logic [7:0]  high_out;
        logic [7:0]  acc_out;
    } result_t;

endpackage

`default_nettype wire

// ----- hw/rtl/cpu_opcode_row_2x_execute.sv -----
// Execute stage for CPU opcodes 0x20..0x2F: request register, execute logic,
// architectural registers A/H/L/flags/PC and result register.
// Depends on cpr2x_pkg and cpr2x_alu.
//
// Usage:
//   s_axis: one request per instruction, tdata = {mem_data, imm_hi, imm_lo, func}.
//   m_axis: one result per request, fields packed as listed at the m_tdata port.
//   A request is captured in the input register; it is then executed against
//   the current A/H/L/flags/PC once the output register is empty or being
//   taken, and the result lands in the output register, which drives m_tvalid.
//   Throughput is one instruction per cycle while the receiver does not stall:
//   the only loop is the register file feeding the combinational execute logic.
//   Both stages advance independently: a new request is taken while a result
//   waits, as long as the input register can move on or is empty.
//   When the receiver stalls, the result register holds, the input register
//   fills, then s_tready drops; nothing is lost or duplicated.
//   Reset (aresetn low, synchronous) clears A, H, L, flags and PC to zero and
//   empties both stages.
`default_nettype none

module cpu_opcode_row_2x_execute (
    input  wire         aclk,
    input  wire         aresetn,
    input  wire         s_tvalid,
    output logic        s_tready,
    // [3:0] func, [11:4] imm_lo, [19:12] imm_hi, [27:20] mem_data, [31:28] zero
    input  wire  [31:0] s_tdata,
    output logic        m_tvalid,
    input  wire         m_tready,
    // [7:0] acc_out, [15:8] high_out, [23:16] low_out, [24] zero_flag,
    // [25] subtract_flag, [26] half_carry_flag, [27] carry_flag, [43:28] pc_out,
    // [44] write_enable, [60:45] write_addr, [68:61] write_data,
    // [72:69] clock_cost, [79:73] zero
    output logic [79:0] m_tdata
);

    logic                   in_valid_reg;
    logic                   in_valid_next;
    cpr2x_pkg::item_t       item_reg;
    logic                   out_valid_reg;
    logic                   out_valid_next;
    cpr2x_pkg::result_t     result_reg;
    cpr2x_pkg::cpu_state_t  state_reg;
    cpr2x_pkg::cpu_state_t  state_next;
    cpr2x_pkg::result_t     result_next;
    logic                   advance;
    logic                   accept;

    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;
    assign accept   = s_tvalid && s_tready;

    assign in_valid_next  = accept || (in_valid_reg && !advance);
    assign out_valid_next = advance || (out_valid_reg && !m_tready);

    cpr2x_alu u_alu (
        .st      (state_reg),
        .item    (item_reg),
        .st_next (state_next),
        .res     (result_next)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            state_reg     <= '0;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
            if (advance) begin
                state_reg <= state_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            item_reg <= cpr2x_pkg::item_t'(s_tdata[27:0]);
        end
        if (advance) begin
            result_reg <= result_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {7'd0, result_reg};

    // a result without a memory write carries zero address and data
    a_no_write_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid_reg && !result_reg.write_enable) |->
        (result_reg.write_addr == 16'h0000 && result_reg.write_data == 8'h00))
        else $error("write fields non-zero without write_enable");

    a_cost_legal: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg |->
        (result_reg.clock_cost == cpr2x_pkg::COST_1M ||
         result_reg.clock_cost == cpr2x_pkg::COST_2M ||
         result_reg.clock_cost == cpr2x_pkg::COST_3M))
        else $error("illegal clock_cost");

    a_reset_clear: assert property (@(posedge aclk)
        !aresetn |=> (!in_valid_reg && !out_valid_reg && state_reg == '0))
        else $error("reset did not clear pipeline and registers");

    a_result_mirrors_state: assert property (@(posedge aclk) disable iff (!aresetn)
        advance |=> (result_reg.pc_out == state_reg.pc &&
                     result_reg.acc_out == state_reg.acc &&
                     {result_reg.high_out, result_reg.low_out} ==
                     {state_reg.high, state_reg.low}))
        else $error("result does not match updated registers");

    a_state_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        (!advance && $past(aresetn)) |=> $stable(state_reg))
        else $error("registers changed without an executed request");

endmodule

`default_nettype wire

// ----- hw/rtl/cpr2x_alu.sv -----
// Combinational execute logic for opcodes 0x20..0x2F: next register state
// and the result item from the current state and one instruction.
// Depends on cpr2x_pkg.
`default_nettype none

module cpr2x_alu (
    input  wire cpr2x_pkg::cpu_state_t st,
    input  wire cpr2x_pkg::item_t      item,
    output cpr2x_pkg::cpu_state_t      st_next,
    output cpr2x_pkg::result_t         res
);

    logic [15:0] hl;
    logic [15:0] hl_inc;
    logic [15:0] hl_dec;
    logic [15:0] pc_inc1;
    logic [15:0] pc_inc2;
    logic [15:0] pc_jump;
    logic [7:0]  r8_src;
    logic [7:0]  r8_inc;
    logic [7:0]  r8_dec;
    logic [8:0]  daa_lo;
    logic [8:0]  daa_add;
    logic        daa_carry;
    logic [7:0]  daa_sub;
    logic [7:0]  daa_res;
    logic        take;
    logic        we;
    logic [3:0]  cost;

    assign hl      = {st.high, st.low};
    assign hl_inc  = hl + 16'd1;
    assign hl_dec  = hl - 16'd1;
    assign pc_inc1 = st.pc + 16'd1;
    assign pc_inc2 = st.pc + 16'd2;
    assign pc_jump = pc_inc1 + {{8{item.imm_lo[7]}}, item.imm_lo};

    // INC/DEC share one source selector: L for the 0x2C/0x2D pair, else H
    assign r8_src = item.func[3] ? st.low : st.high;
    assign r8_inc = r8_src + 8'd1;
    assign r8_dec = r8_src - 8'd1;

    // DAA after addition: low correction first, then high on the grown value
    assign daa_lo = (st.flags[cpr2x_pkg::FLAG_H] || (st.acc[3:0] > 4'h9))
                    ? {1'b0, st.acc} + 9'h006 : {1'b0, st.acc};
    assign daa_carry = st.flags[cpr2x_pkg::FLAG_C] || (daa_lo > 9'h09F);
    assign daa_add   = daa_carry ? daa_lo + 9'h060 : daa_lo;
    // DAA after subtraction
    assign daa_sub = st.acc
                     - (st.flags[cpr2x_pkg::FLAG_H] ? 8'h06 : 8'h00)
                     - (st.flags[cpr2x_pkg::FLAG_C] ? 8'h60 : 8'h00);
    assign daa_res = st.flags[cpr2x_pkg::FLAG_N] ? daa_sub : daa_add[7:0];

    always_comb begin
        st_next = st;
        take    = 1'b0;
        we      = 1'b0;
        cost    = cpr2x_pkg::COST_1M;
        unique case (cpr2x_pkg::func_t'(item.func))
            cpr2x_pkg::FN_JR_NZ, cpr2x_pkg::FN_JR_Z: begin
                take = item.func[3] ? st.flags[cpr2x_pkg::FLAG_Z]
                                    : !st.flags[cpr2x_pkg::FLAG_Z];
                st_next.pc = take ? pc_jump : pc_inc1;
                cost       = take ? cpr2x_pkg::COST_3M : cpr2x_pkg::COST_2M;
            end
            cpr2x_pkg::FN_LD_HL_NN: begin
                st_next.low  = item.imm_lo;
                st_next.high = item.imm_hi;
                st_next.pc   = pc_inc2;
                cost         = cpr2x_pkg::COST_3M;
            end
            cpr2x_pkg::FN_LDI_M_A: begin
                we = 1'b1;
                {st_next.high, st_next.low} = hl_inc;
                cost = cpr2x_pkg::COST_2M;
            end
            cpr2x_pkg::FN_INC_HL: begin
                {st_next.high, st_next.low} = hl_inc;
                cost = cpr2x_pkg::COST_2M;
            end
            cpr2x_pkg::FN_INC_H, cpr2x_pkg::FN_INC_L: begin
                if (item.func[3]) begin
                    st_next.low = r8_inc;
                end else begin
                    st_next.high = r8_inc;
                end
                st_next.flags[cpr2x_pkg::FLAG_Z] = (r8_inc == 8'h00);
                st_next.flags[cpr2x_pkg::FLAG_N] = 1'b0;
                st_next.flags[cpr2x_pkg::FLAG_H] = (r8_src[3:0] == 4'hF);
            end
            cpr2x_pkg::FN_DEC_H, cpr2x_pkg::FN_DEC_L: begin
                if (item.func[3]) begin
                    st_next.low = r8_dec;
                end else begin
                    st_next.high = r8_dec;
                end
                st_next.flags[cpr2x_pkg::FLAG_Z] = (r8_dec == 8'h00);
                st_next.flags[cpr2x_pkg::FLAG_N] = 1'b1;
                st_next.flags[cpr2x_pkg::FLAG_H] = (r8_src[3:0] == 4'h0);
            end
            cpr2x_pkg::FN_LD_H_N: begin
                st_next.high = item.imm_lo;
                st_next.pc   = pc_inc1;
                cost         = cpr2x_pkg::COST_2M;
            end
            cpr2x_pkg::FN_LD_L_N: begin
                st_next.low = item.imm_lo;
                st_next.pc  = pc_inc1;
                cost        = cpr2x_pkg::COST_2M;
            end
            cpr2x_pkg::FN_DAA: begin
                st_next.acc = daa_res;
                st_next.flags[cpr2x_pkg::FLAG_Z] = (daa_res == 8'h00);
                st_next.flags[cpr2x_pkg::FLAG_H] = 1'b0;
                st_next.flags[cpr2x_pkg::FLAG_C] =
                    st.flags[cpr2x_pkg::FLAG_N] ? st.flags[cpr2x_pkg::FLAG_C] : daa_carry;
            end
            cpr2x_pkg::FN_ADD_HLHL: begin
                // doubling: carries out of bits 11 and 15 are just those bits
                {st_next.high, st_next.low} = {hl[14:0], 1'b0};
                st_next.flags[cpr2x_pkg::FLAG_N] = 1'b0;
                st_next.flags[cpr2x_pkg::FLAG_H] = hl[11];
                st_next.flags[cpr2x_pkg::FLAG_C] = hl[15];
                cost = cpr2x_pkg::COST_2M;
            end
            cpr2x_pkg::FN_LDI_A_M: begin
                st_next.acc = item.mem_data;
                {st_next.high, st_next.low} = hl_inc;
                cost = cpr2x_pkg::COST_2M;
            end
            cpr2x_pkg::FN_DEC_HL: begin
                {st_next.high, st_next.low} = hl_dec;
                cost = cpr2x_pkg::COST_2M;
            end
            cpr2x_pkg::FN_CPL: begin
                st_next.acc = ~st.acc;
                st_next.flags[cpr2x_pkg::FLAG_N] = 1'b1;
                st_next.flags[cpr2x_pkg::FLAG_H] = 1'b1;
            end
            default: begin
                st_next = st;
            end
        endcase
    end

    always_comb begin
        res.acc_out         = st_next.acc;
        res.high_out        = st_next.high;
        res.low_out         = st_next.low;
        res.zero_flag       = st_next.flags[cpr2x_pkg::FLAG_Z];
        res.subtract_flag   = st_next.flags[cpr2x_pkg::FLAG_N];
        res.half_carry_flag = st_next.flags[cpr2x_pkg::FLAG_H];
        res.carry_flag      = st_next.flags[cpr2x_pkg::FLAG_C];
        res.pc_out          = st_next.pc;
        res.write_enable    = we;
        res.write_addr      = we ? hl : 16'h0000;
        res.write_data      = we ? st.acc : 8'h00;
        res.clock_cost      = cost;
    end

endmodule

`default_nettype wire
